@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/stis_pkg.sv @@
`timescale 1ns / 1ps
package stis_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = 11;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Numeric compare of two doubles: CMP_LT a<b, CMP_EQ equal, CMP_GT a>b (no NaN support).
    typedef enum logic [1:0] {
        CMP_LT = 2'b01,
        CMP_EQ = 2'b00,
        CMP_GT = 2'b10
    } cmp_t;

    function automatic cmp_t fp_compare(input logic [63:0] a, input logic [63:0] b);
        logic a_zero;
        logic b_zero;
        logic mag_gt;
        logic mag_eq;
        cmp_t res;
        a_zero = (a[62:0] == 63'd0);
        b_zero = (b[62:0] == 63'd0);
        mag_gt = (a[62:0] > b[62:0]);
        mag_eq = (a[62:0] == b[62:0]);
        if (a_zero && b_zero) begin
            res = CMP_EQ;
        end
        else if (a[63] != b[63]) begin
            res = a[63] ? CMP_LT : CMP_GT;
        end
        else if (mag_eq) begin
            res = CMP_EQ;
        end
        else if (a[63]) begin
            res = mag_gt ? CMP_LT : CMP_GT;
        end
        else begin
            res = mag_gt ? CMP_GT : CMP_LT;
        end
        return res;
    endfunction
endpackage

@@ rtl/core/sorted_table_interval_search.sv @@
`timescale 1ns / 1ps
// Predecessor binary search over a 1024-entry table of doubles held in one
// synchronous RAM. A load beat (mode 0) writes one entry and gives no
// result. A search beat (mode 1) bisects [range_first, range_last]. Each
// step is a RAM read state (READ) followed by a compare state (CMP), and a
// search takes at most 11 steps. A match goes to DONE from its compare; a
// miss goes to DONE from the READ that finds the range empty. An empty range
// goes to DONE from READ without a compare. One search runs at a time. The
// result waits in its own output register, so the next beat is accepted as
// soon as the sequencer is idle. A finished search holds in its last state
// while the previous result is still waiting.
`include "assert_macros.svh"
module sorted_table_interval_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [9:0]                  entry_index,
    input  logic [63:0]                 data_word,
    input  logic [9:0]                  range_first,
    input  logic signed [10:0]          range_last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [10:0]          position,
    output logic                        exact_hit
);
    localparam int AW = stis_pkg::ADDR_W;
    localparam int PW = stis_pkg::POS_W;

    // Table memory
    logic [63:0] mem [stis_pkg::TABLE_DEPTH];
    logic [63:0] rd_data_reg;

    stis_pkg::state_t state_reg, state_next;
    logic signed [PW:0]   lo_reg, lo_next;
    logic signed [PW-1:0] hi_reg, hi_next;
    logic signed [PW-1:0] mid_reg, mid_next;
    logic [63:0]          key_reg, key_next;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [PW-1:0] pos_out_reg, pos_out_next;
    logic                 hit_out_reg, hit_out_next;

    logic in_fire;
    logic load_fire;
    logic signed [PW:0] hi_ext;
    logic signed [PW:0] sum;
    stis_pkg::cmp_t cmp;

    assign in_stall  = (state_reg != stis_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign load_fire = in_fire && (mode == stis_pkg::MODE_LOAD);
    assign out_valid = out_valid_reg;
    assign position  = pos_out_reg;
    assign exact_hit = hit_out_reg;

    // lo can reach 1024 after a step past the top entry
    assign hi_ext = {hi_reg[PW-1], hi_reg};
    assign sum    = lo_reg + hi_ext;
    assign cmp    = stis_pkg::fp_compare(key_reg, rd_data_reg);

    // Memory write and registered read of the midpoint being set up
    always_ff @(posedge clk)
    begin
        if (load_fire && ({1'b0, entry_index} < 11'(stis_pkg::TABLE_DEPTH))) begin
            mem[entry_index[AW-1:0]] <= data_word;
        end
        rd_data_reg <= mem[mid_next[AW-1:0]];
    end

    // Search sequencer
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        pos_out_next   = pos_out_reg;
        hit_out_next   = hit_out_reg;
        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            stis_pkg::ST_IDLE:
            begin
                if (in_fire && (mode == stis_pkg::MODE_SEARCH)) begin
                    lo_next   = {2'b00, range_first};
                    hi_next   = range_last;
                    key_next  = data_word;
                    hit_next  = 1'b0;
                    state_next = stis_pkg::ST_READ;
                end
            end
            stis_pkg::ST_READ:
            begin
                if (lo_reg > hi_ext) begin
                    state_next = stis_pkg::ST_DONE;
                end
                else begin
                    mid_next   = sum[PW:1];
                    state_next = stis_pkg::ST_CMP;
                end
            end
            stis_pkg::ST_CMP:
            begin
                // rd_data_reg now holds the entry at mid
                case (cmp)
                    stis_pkg::CMP_GT: begin
                        lo_next    = {mid_reg[PW-1], mid_reg} + 12'sd1;
                        state_next = stis_pkg::ST_READ;
                    end
                    stis_pkg::CMP_LT: begin
                        hi_next    = mid_reg - 11'sd1;
                        state_next = stis_pkg::ST_READ;
                    end
                    default: begin
                        hi_next    = mid_reg;
                        hit_next   = 1'b1;
                        state_next = stis_pkg::ST_DONE;
                    end
                endcase
            end
            stis_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall) begin
                    out_valid_next = 1'b1;
                    pos_out_next   = hi_reg;
                    hit_out_next   = hit_reg;
                    state_next     = stis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stis_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= stis_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        key_reg     <= key_next;
        hit_reg     <= hit_next;
        pos_out_reg <= pos_out_next;
        hit_out_reg <= hit_out_next;
    end

    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, state_reg != stis_pkg::ST_IDLE, in_stall, "accepted beat while searching")
    `ASSERT_NEXT(a_done_gives_result, clk, rst_n, state_reg == stis_pkg::ST_DONE, out_valid, "search finished without result")
    `ASSERT_IMPLIES(a_hit_in_range, clk, rst_n, out_valid && exact_hit, position >= 11'sd0, "exact hit at negative index")
endmodule
